[hw/rtl/pcaf_pkg.sv]
// Package with the shared constants, the arctangent table and the register indexes.
package pcaf_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int TRIG_ITER_DEF = 18;
    localparam int CORDIC_MAX = 30;
    localparam int COEF_WIDTH = 32;
    localparam int COEF_FRAC = 16;

    localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] TWO_PI_Q30 = 34'sd6746518852;
    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611B;

    localparam logic [1:0] MODE_CART = 2'd0;
    localparam logic [1:0] MODE_CYL = 2'd1;
    localparam logic [1:0] MODE_SPH = 2'd2;
    localparam logic [1:0] MODE_PASS = 2'd3;

    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_R0_AB = 3'd1;
    localparam logic [2:0] REG_R0_CO = 3'd2;
    localparam logic [2:0] REG_R1_AB = 3'd3;
    localparam logic [2:0] REG_R1_CO = 3'd4;
    localparam logic [2:0] REG_R2_AB = 3'd5;
    localparam logic [2:0] REG_R2_CO = 3'd6;

    function automatic logic signed [33:0] atan_q30(input int i);
        logic signed [33:0] t;
        case (i)
            0: t = 34'sd843314857;
            1: t = 34'sd497837829;
            2: t = 34'sd263043837;
            3: t = 34'sd133525159;
            4: t = 34'sd67021687;
            5: t = 34'sd33543516;
            6: t = 34'sd16775851;
            7: t = 34'sd8388437;
            8: t = 34'sd4194283;
            9: t = 34'sd2097149;
            default: t = (i < 30) ? (34'sd1 << (30 - i)) : 34'sd0;
        endcase
        return t;
    endfunction

endpackage

[hw/rtl/pcaf_cordic.sv]
// Pipelined angle reduction and CORDIC sine and cosine, one rotation per stage.
module pcaf_cordic #(
    parameter int COORD_WIDTH = pcaf_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS = pcaf_pkg::FRAC_BITS_DEF,
    parameter int TRIG_ITERATIONS = pcaf_pkg::TRIG_ITER_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic signed [COORD_WIDTH-1:0] i_ang,
    output logic signed [33:0]            o_cos,
    output logic signed [33:0]            o_sin
);
    localparam int ASH = ((61 - COORD_WIDTH) < (60 - FRAC_BITS)) ?
                         (61 - COORD_WIDTH) : (60 - FRAC_BITS);
    localparam int ZF = FRAC_BITS + ASH;
    localparam int UW = COORD_WIDTH + ASH;
    localparam logic [63:0] PMOD = (ZF >= 60) ? pcaf_pkg::TWO_PI_Q60 :
        ((pcaf_pkg::TWO_PI_Q60 + (64'd1 << (59 - ZF))) >> (60 - ZF));
    localparam int NI = (TRIG_ITERATIONS < pcaf_pkg::CORDIC_MAX) ?
                        TRIG_ITERATIONS : pcaf_pkg::CORDIC_MAX;
    localparam int QB = COORD_WIDTH + 2;
    localparam int KW = COORD_WIDTH - FRAC_BITS + 1;
    localparam logic [63:0] RECIP = ((64'd1 << (COORD_WIDTH + ASH)) + (PMOD >> 1)) / PMOD;

    // Reduction: remainder of u by PMOD via quotient estimate, one step a stage.
    logic signed [63:0] r_u;
    logic signed [QB-1:0] r_q;
    logic signed [63:0] r_rem;
    logic signed [33:0] r_z0;
    logic r_neg0;
    logic signed [63:0] n_u;
    logic signed [63:0] n_rem;
    logic signed [33:0] n_z;
    logic signed [33:0] n_z2;
    logic n_neg;
    logic signed [QB-1:0] n_q;
    logic signed [COORD_WIDTH+KW:0] n_qp;
    logic signed [63:0] rem_a;

    always_comb begin
        n_u = 64'(i_ang) <<< ASH;
        // The reciprocal estimate is off by at most one; the next stage corrects it.
        n_qp = i_ang * signed'({1'b0, RECIP[KW-1:0]});
        n_q = QB'(n_qp >>> COORD_WIDTH);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u <= n_u;
            r_q <= n_q;
            r_rem <= n_rem;
            r_z0 <= n_z2;
            r_neg0 <= n_neg;
        end
    end

    always_comb begin
        rem_a = r_u - 64'(r_q) * signed'({1'b0, PMOD[62:0]});
        if (rem_a < 0) n_rem = rem_a + signed'({1'b0, PMOD[62:0]});
        else if (rem_a >= signed'({1'b0, PMOD[62:0]})) n_rem = rem_a - signed'({1'b0, PMOD[62:0]});
        else n_rem = rem_a;
    end

    always_comb begin
        if (ZF > 30) n_z = 34'((r_rem + (64'sd1 <<< ((ZF > 30) ? ZF - 31 : 0)))
                              >>> ((ZF > 30) ? ZF - 30 : 0));
        else n_z = 34'(r_rem <<< ((ZF > 30) ? 0 : 30 - ZF));
        if (n_z > pcaf_pkg::PI_Q30) n_z = n_z - pcaf_pkg::TWO_PI_Q30;
        n_neg = 1'b0;
        n_z2 = n_z;
        if (n_z > pcaf_pkg::HALF_PI_Q30) begin
            n_z2 = n_z - pcaf_pkg::PI_Q30;
            n_neg = 1'b1;
        end else if (n_z < -pcaf_pkg::HALF_PI_Q30) begin
            n_z2 = n_z + pcaf_pkg::PI_Q30;
            n_neg = 1'b1;
        end
    end

    logic signed [33:0] r_x [NI+1];
    logic signed [33:0] r_y [NI+1];
    logic signed [33:0] r_z [NI+1];
    logic r_ng [NI+1];

    always_comb begin
        r_x[0] = pcaf_pkg::GAIN_Q30;
        r_y[0] = '0;
        r_z[0] = r_z0;
        r_ng[0] = r_neg0;
    end

    for (genvar g = 0; g < NI; g++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[g] >= 0) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - pcaf_pkg::atan_q30(g);
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + pcaf_pkg::atan_q30(g);
                end
                r_ng[g+1] <= r_ng[g];
            end
        end
    end

    assign o_cos = r_ng[NI] ? -r_x[NI] : r_x[NI];
    assign o_sin = r_ng[NI] ? -r_y[NI] : r_y[NI];
endmodule

[hw/rtl/polar_to_cartesian_affine_unit.sv]
// Top level: coordinate conversion and affine transform pipeline with APB registers.
//  channel  | valid / ready           | payload
//  input    | i_valid / o_ready       | i_coord_a, i_coord_b, i_coord_c
//  output   | o_valid / i_ready       | o_out_x, o_out_y, o_out_z, o_saturated
//  config   | psel, penable, pwrite   | paddr, pwdata, prdata, pready
// One point enters per cycle while o_ready is high; the pipeline depth is set by the CORDIC chain.
// Reset clears the valid bits and loads the register reset values.
// When the output is not taken, the whole pipeline holds; no beat is lost or repeated.
module polar_to_cartesian_affine_unit #(
    parameter int COORD_WIDTH = pcaf_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS = pcaf_pkg::FRAC_BITS_DEF,
    parameter int TRIG_ITERATIONS = pcaf_pkg::TRIG_ITER_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_coord_a,
    input  logic signed [COORD_WIDTH-1:0] i_coord_b,
    input  logic signed [COORD_WIDTH-1:0] i_coord_c,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0] o_out_x,
    output logic signed [COORD_WIDTH-1:0] o_out_y,
    output logic signed [COORD_WIDTH-1:0] o_out_z,
    output logic                          o_saturated,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [5:0]                    paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready
);
    localparam int NI = (TRIG_ITERATIONS < pcaf_pkg::CORDIC_MAX) ?
                        TRIG_ITERATIONS : pcaf_pkg::CORDIC_MAX;
    localparam int TL = NI + 3;
    localparam int DEPTH = TL + 7;
    localparam int W = COORD_WIDTH;

    logic [1:0] r_mode;
    logic [63:0] r_row [6];
    logic [2:0] reg_idx;

    assign pready = 1'b1;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= pcaf_pkg::MODE_CART;
            r_row[0] <= 64'd65536;
            r_row[1] <= 64'd0;
            r_row[2] <= 64'd65536 << 32;
            r_row[3] <= 64'd0;
            r_row[4] <= 64'd0;
            r_row[5] <= 64'd65536;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                pcaf_pkg::REG_MODE: r_mode <= pwdata[1:0];
                pcaf_pkg::REG_R0_AB: r_row[0] <= pwdata;
                pcaf_pkg::REG_R0_CO: r_row[1] <= pwdata;
                pcaf_pkg::REG_R1_AB: r_row[2] <= pwdata;
                pcaf_pkg::REG_R1_CO: r_row[3] <= pwdata;
                pcaf_pkg::REG_R2_AB: r_row[4] <= pwdata;
                pcaf_pkg::REG_R2_CO: r_row[5] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            pcaf_pkg::REG_MODE: prdata = {62'd0, r_mode};
            pcaf_pkg::REG_R0_AB: prdata = r_row[0];
            pcaf_pkg::REG_R0_CO: prdata = r_row[1];
            pcaf_pkg::REG_R1_AB: prdata = r_row[2];
            pcaf_pkg::REG_R1_CO: prdata = r_row[3];
            pcaf_pkg::REG_R2_AB: prdata = r_row[4];
            pcaf_pkg::REG_R2_CO: prdata = r_row[5];
            default: prdata = '0;
        endcase
    end

    logic en;
    assign en = !o_valid || i_ready;
    assign o_ready = en;

    logic r_vld [DEPTH];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) r_vld[k] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < DEPTH; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // Point delay line alongside the CORDIC units.
    logic signed [W-1:0] r_da [TL];
    logic signed [W-1:0] r_db [TL];
    logic signed [W-1:0] r_dc [TL];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_da[0] <= i_coord_a;
            r_db[0] <= i_coord_b;
            r_dc[0] <= i_coord_c;
            for (int k = 1; k < TL; k++) begin
                r_da[k] <= r_da[k-1];
                r_db[k] <= r_db[k-1];
                r_dc[k] <= r_dc[k-1];
            end
        end
    end

    logic signed [33:0] cb, sb, cc, sc;
    pcaf_cordic #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS))
        u_trig_b (.i_clk(i_clk), .i_en(en), .i_ang(i_coord_b), .o_cos(cb), .o_sin(sb));
    pcaf_cordic #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS), .TRIG_ITERATIONS(TRIG_ITERATIONS))
        u_trig_c (.i_clk(i_clk), .i_en(en), .i_ang(i_coord_c), .o_cos(cc), .o_sin(sc));

    function automatic logic signed [63:0] rnd30(input logic signed [W+33:0] p);
        logic signed [W+33:0] t;
        t = (p + (1 <<< 29)) >>> 30;
        return 64'(t);
    endfunction

    // Stage T1: radius products.
    logic signed [W+33:0] r_pcb, r_psb;
    logic signed [W-1:0] r_a1, r_b1, r_c1;
    logic signed [33:0] r_cc1, r_sc1;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pcb <= r_da[TL-1] * cb;
            r_psb <= r_da[TL-1] * sb;
            r_a1 <= r_da[TL-1];
            r_b1 <= r_db[TL-1];
            r_c1 <= r_dc[TL-1];
            r_cc1 <= cc;
            r_sc1 <= sc;
        end
    end

    // Stage T2: rounding.
    logic signed [W+1:0] r_rcb, r_rsb;
    logic signed [W-1:0] r_a2, r_b2, r_c2;
    logic signed [33:0] r_cc2, r_sc2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rcb <= (W+2)'(rnd30(r_pcb));
            r_rsb <= (W+2)'(rnd30(r_psb));
            r_a2 <= r_a1;
            r_b2 <= r_b1;
            r_c2 <= r_c1;
            r_cc2 <= r_cc1;
            r_sc2 <= r_sc1;
        end
    end

    // Stage T3: azimuth products for spherical points.
    logic signed [W+35:0] r_pxc, r_pys;
    logic signed [W+1:0] r_rcb3, r_rsb3;
    logic signed [W-1:0] r_a3, r_b3, r_c3;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pxc <= r_rsb * r_cc2;
            r_pys <= r_rsb * r_sc2;
            r_rcb3 <= r_rcb;
            r_rsb3 <= r_rsb;
            r_a3 <= r_a2;
            r_b3 <= r_b2;
            r_c3 <= r_c2;
        end
    end

    // Stage T4: select Cartesian coordinates.
    logic signed [W+1:0] r_x4, r_y4, r_z4;
    logic signed [W-1:0] r_a4, r_b4, r_c4;
    logic signed [W+35:0] hxc, hys;
    always_comb begin
        hxc = (r_pxc + (1 <<< 29)) >>> 30;
        hys = (r_pys + (1 <<< 29)) >>> 30;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a4 <= r_a3;
            r_b4 <= r_b3;
            r_c4 <= r_c3;
            case (r_mode)
                pcaf_pkg::MODE_CYL: begin
                    r_x4 <= r_rcb3;
                    r_y4 <= r_rsb3;
                    r_z4 <= (W+2)'(r_c3);
                end
                pcaf_pkg::MODE_SPH: begin
                    r_x4 <= (W+2)'(hxc);
                    r_y4 <= (W+2)'(hys);
                    r_z4 <= r_rcb3;
                end
                default: begin
                    r_x4 <= (W+2)'(r_a3);
                    r_y4 <= (W+2)'(r_b3);
                    r_z4 <= (W+2)'(r_c3);
                end
            endcase
        end
    end

    // Stage T5: nine products and translations.
    localparam int PW = W + 34;
    logic signed [PW-1:0] r_pr [3][4];
    logic signed [W-1:0] r_a5, r_b5, r_c5;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_pr[k][0] <= signed'(r_row[2*k][31:0]) * r_x4;
                r_pr[k][1] <= signed'(r_row[2*k][63:32]) * r_y4;
                r_pr[k][2] <= signed'(r_row[2*k+1][31:0]) * r_z4;
                r_pr[k][3] <= PW'(signed'(r_row[2*k+1][63:32])) <<< FRAC_BITS;
            end
            r_a5 <= r_a4;
            r_b5 <= r_b4;
            r_c5 <= r_c4;
        end
    end

    // Stage T6: sums and rounding; T7: saturation.
    logic signed [PW+1:0] r_sum [3];
    logic signed [W-1:0] r_a6, r_b6, r_c6;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++)
                r_sum[k] <= ((PW+2)'(r_pr[k][0]) + (PW+2)'(r_pr[k][1]) + (PW+2)'(r_pr[k][2])
                            + (PW+2)'(r_pr[k][3]) + (PW+2)'(1 <<< 15)) >>> pcaf_pkg::COEF_FRAC;
            r_a6 <= r_a5;
            r_b6 <= r_b5;
            r_c6 <= r_c5;
        end
    end

    localparam logic signed [PW+1:0] MAXV = (PW+2)'((64'sd1 <<< (W - 1)) - 1);
    localparam logic signed [PW+1:0] MINV = -MAXV - 1;
    logic signed [W-1:0] r_o [3];
    logic r_sat;
    logic signed [W-1:0] sv [3];
    logic clip;
    always_comb begin
        clip = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (r_sum[k] > MAXV) begin
                sv[k] = MAXV[W-1:0];
                clip = 1'b1;
            end else if (r_sum[k] < MINV) begin
                sv[k] = MINV[W-1:0];
                clip = 1'b1;
            end else begin
                sv[k] = r_sum[k][W-1:0];
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_mode == pcaf_pkg::MODE_PASS) begin
                r_o[0] <= r_a6;
                r_o[1] <= r_b6;
                r_o[2] <= r_c6;
                r_sat <= 1'b0;
            end else begin
                r_o[0] <= sv[0];
                r_o[1] <= sv[1];
                r_o[2] <= sv[2];
                r_sat <= clip;
            end
        end
    end

    assign o_valid = r_vld[DEPTH-1];
    assign o_out_x = r_o[0];
    assign o_out_y = r_o[1];
    assign o_out_z = r_o[2];
    assign o_saturated = r_sat;

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_x) && $stable(o_saturated))
        else $error("output beat changed under stall");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready) else $error("ready low with empty output");
    a_pass_nosat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_mode == pcaf_pkg::MODE_PASS |-> !o_saturated)
        else $error("saturation flagged in pass through");
`endif
endmodule
